// ----- rtl/core/lscc_pkg.sv -----
// Shared types and codes of the line sensor calibrate-and-centroid block.
package lscc_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_CALIBRATE = 2'd0;
  localparam logic [1:0] OP_MEASURE   = 2'd1;
  localparam logic [1:0] OP_CLEAR     = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_MAX       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_PITCH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ACTIVE     = 3'd5;
  localparam int unsigned CFG_DATA_W = 16;

  // Width of the normalization numerator (12-bit difference times 12-bit full scale)
  localparam int unsigned NORM_NUM_W = 24;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  sensor_index;
    logic [11:0] raw_value;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        normalized;
    logic               scan_done;
    logic signed [15:0] position;
    logic               line_lost;
    logic               crossing;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // latch the accepted input item
    logic do_cal;      // widen the sensor's window
    logic do_clr;      // clear calibration and accumulators
    logic prep_num;    // form numerator, range and sensor offset
    logic norm_start;  // form half span and start the normalizing division
    logic norm_take;   // take the normalized value from the divider
    logic do_mul;      // position times normalized value
    logic do_acc;      // accumulate the scan sums
    logic fin_lost;    // report the held position for a lost line
    logic cdiv_start;  // start the centroid division
    logic cdiv_take;   // take the centroid from the divider
    logic out_load;    // move the finished result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] op;
    logic       div_done;
    logic       last;
    logic       lost;
    logic       out_full;
  } status_t;

endpackage

// ----- rtl/core/lscc_divider.sv -----
// Restoring divider, one quotient bit per cycle, with a short mode for 24-bit dividends.
module lscc_divider #(
  parameter int unsigned N = 35,  // dividend and quotient width
  parameter int unsigned M = 17   // divisor width
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         short_i,
  input  logic [N-1:0] dividend_i,
  input  logic [M-1:0] divisor_i,
  output logic [N-1:0] quotient_o,
  output logic         done_o
);
  import lscc_pkg::*;

  localparam int unsigned StepW = $clog2(N + 1);

  logic [N-1:0]     quo_q;
  logic [M-1:0]     rem_q;
  logic [M-1:0]     div_q;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic             done_q;

  logic [M:0]       rem_sh;
  logic             fits;

  // Shift in the next dividend bit and trial-subtract
  assign rem_sh = {rem_q, quo_q[N-1]};
  assign fits   = rem_sh >= {1'b0, div_q};

  // Payload: quotient, remainder and divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[N-2:0], fits};
      rem_q <= fits ? M'(rem_sh - {1'b0, div_q}) : M'(rem_sh);
    end
  end

  // Step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= short_i ? StepW'(NORM_NUM_W) : StepW'(N);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        step_q <= step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ----- rtl/core/lscc_datapath.sv -----
// Datapath: configuration, calibration windows, scan accumulators, divider and output register.
module lscc_datapath #(
  parameter int unsigned MAX_SENSOR_COUNT = 16,
  parameter int unsigned SAMPLE_BITS      = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lscc_pkg::cmd_t                      cmd_i,
  output lscc_pkg::status_t                   status_o,
  input  lscc_pkg::in_item_t                  in_item_i,
  input  logic                                cfg_valid_i,
  input  logic [lscc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lscc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lscc_pkg::out_item_t                 out_item_o
);
  import lscc_pkg::*;

  localparam int unsigned IdxW  = (MAX_SENSOR_COUNT > 1) ? $clog2(MAX_SENSOR_COUNT) : 1;
  localparam int unsigned CntW  = $clog2(MAX_SENSOR_COUNT + 1);
  localparam int unsigned CW    = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
  localparam int unsigned HW    = CntW + 12;
  localparam int unsigned PidxW = IdxW + 12;
  localparam int unsigned PW    = CntW + 13;
  localparam int unsigned PrW   = PW + 13;
  localparam int unsigned WsW   = PrW + IdxW;
  localparam int unsigned SumW  = CntW + 12;
  localparam int unsigned CmpW  = (SumW > 16) ? SumW : 16;
  localparam logic [11:0] RawMask =
      (SAMPLE_BITS >= 12) ? 12'hFFF : 12'((1 << SAMPLE_BITS) - 1);

  // Configuration registers
  logic [4:0]  sc_q;
  logic [11:0] nmax_q;
  logic [11:0] scale_q;
  logic [11:0] alev_q;
  logic [15:0] thr_q;
  logic [4:0]  mina_q;

  // Latched input item
  logic [1:0]      op_q;
  logic [IdxW-1:0] idx_q;
  logic [11:0]     raw_q;
  logic [IdxW-1:0] idx_m;

  // Calibration windows
  logic [SAMPLE_BITS-1:0] min_q [MAX_SENSOR_COUNT];
  logic [SAMPLE_BITS-1:0] max_q [MAX_SENSOR_COUNT];

  // Per-item working registers
  logic [NORM_NUM_W-1:0] num_q;
  logic [11:0]           range_q;
  logic                  win_q;
  logic [PidxW-1:0]      pidx_q;
  logic [HW-1:0]         half_q;
  logic [11:0]           norm_q;
  logic signed [PW-1:0]  p_q;
  logic signed [PrW-1:0] prod_q;
  logic                  sign_q;

  // Scan state
  logic [SumW-1:0]       sum_q;
  logic signed [WsW-1:0] ws_q;
  logic [4:0]            act_q;
  logic signed [15:0]    last_pos_q;

  // Staged result and output register
  logic               res_done_q;
  logic signed [15:0] res_pos_q;
  logic               res_lost_q;
  logic               res_cross_q;
  logic               out_valid_q;
  out_item_t          out_item_q;

  // Combinational helpers
  logic [CntW-1:0]        cnt_eff;
  logic [CW-1:0]          raw_c;
  logic [CW-1:0]          min_c;
  logic [CW-1:0]          max_c;
  logic                   win_ok;
  logic                   in_cnt;
  logic                   lost;
  logic [WsW-1:0]         ws_abs;
  logic                   div_start;
  logic [WsW-1:0]         div_dividend;
  logic [SumW-1:0]        div_divisor;
  logic [WsW-1:0]         div_quo;
  logic                   div_done;
  logic [11:0]            norm_d;
  logic signed [15:0]     cent_d;

  // Sensor index folded into the array depth
  always_comb begin
    idx_m = '0;
    for (int i = 0; i < 16; i++) begin
      if (in_item_i.sensor_index == 4'(i)) begin
        idx_m = IdxW'(i % MAX_SENSOR_COUNT);
      end
    end
  end

  // Effective sensor count clamped to [1, MAX_SENSOR_COUNT]
  always_comb begin
    if (sc_q == 5'd0) begin
      cnt_eff = CntW'(1);
    end else if ({1'b0, sc_q} > 6'(MAX_SENSOR_COUNT)) begin
      cnt_eff = CntW'(MAX_SENSOR_COUNT);
    end else begin
      cnt_eff = CntW'(sc_q);
    end
  end

  // Window of the latched sensor
  assign raw_c  = CW'(raw_q);
  assign min_c  = CW'(min_q[idx_q]);
  assign max_c  = CW'(max_q[idx_q]);
  assign win_ok = (max_c > min_c) && (raw_c > min_c);

  assign in_cnt = CntW'(idx_q) < cnt_eff;
  assign lost   = (sum_q == '0) || (CmpW'(sum_q) < CmpW'(thr_q));
  assign ws_abs = ws_q[WsW-1] ? $unsigned(-ws_q) : $unsigned(ws_q);

  // Divider shared by normalization and centroid
  assign div_start    = cmd_i.norm_start | cmd_i.cdiv_start;
  assign div_dividend = cmd_i.norm_start ? {num_q, {(WsW - NORM_NUM_W){1'b0}}} : ws_abs;
  assign div_divisor  = cmd_i.norm_start ? SumW'(range_q) : sum_q;

  lscc_divider #(
    .N (WsW),
    .M (SumW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .short_i    (cmd_i.norm_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  // Normalized value clamped to full scale, zero when the window is not valid
  always_comb begin
    if (!win_q) begin
      norm_d = '0;
    end else if (div_quo > WsW'(nmax_q)) begin
      norm_d = nmax_q;
    end else begin
      norm_d = div_quo[11:0];
    end
  end

  // Signed centroid, saturated to 16 bits
  always_comb begin
    if (sign_q) begin
      cent_d = (div_quo > WsW'(32768)) ? 16'sh8000 : -$signed(div_quo[15:0]);
    end else begin
      cent_d = (div_quo > WsW'(32767)) ? 16'sh7FFF : $signed(div_quo[15:0]);
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q    <= 5'd8;
      nmax_q  <= 12'd1000;
      scale_q <= 12'd1000;
      alev_q  <= 12'd700;
      thr_q   <= 16'd200;
      mina_q  <= 5'd4;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SENSOR_COUNT:   sc_q    <= cfg_data_i[4:0];
        CFG_NORM_MAX:       nmax_q  <= cfg_data_i[11:0];
        CFG_SENSOR_PITCH:   scale_q <= cfg_data_i[11:0];
        CFG_ACTIVE_LEVEL:   alev_q  <= cfg_data_i[11:0];
        CFG_LOST_THRESHOLD: thr_q   <= cfg_data_i[15:0];
        CFG_MIN_ACTIVE:     mina_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Per-item payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_item_i.operation;
      idx_q <= idx_m;
      raw_q <= in_item_i.raw_value & RawMask;
    end
    if (cmd_i.prep_num) begin
      num_q   <= NORM_NUM_W'(12'(raw_c - min_c)) * NORM_NUM_W'(nmax_q);
      range_q <= 12'(max_c - min_c);
      win_q   <= win_ok;
      pidx_q  <= PidxW'(idx_q) * PidxW'(scale_q);
    end
    if (cmd_i.norm_start) begin
      half_q <= HW'(cnt_eff - CntW'(1)) * HW'(scale_q);
    end
    if (cmd_i.norm_take) begin
      norm_q <= norm_d;
      p_q    <= $signed(PW'(pidx_q)) - $signed(PW'(half_q >> 1));
    end
    if (cmd_i.do_mul) begin
      prod_q <= PrW'(p_q) * PrW'($signed({1'b0, norm_q}));
    end
    if (cmd_i.cdiv_start) begin
      sign_q <= ws_q[WsW-1];
    end
  end

  // Calibration windows, widened by a calibrate item and cleared by reset and by a clear item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SENSOR_COUNT; i++) begin
        min_q[i] <= '1;
        max_q[i] <= '0;
      end
    end else if (cmd_i.do_clr) begin
      for (int i = 0; i < MAX_SENSOR_COUNT; i++) begin
        min_q[i] <= '1;
        max_q[i] <= '0;
      end
    end else if (cmd_i.do_cal) begin
      if (raw_c < min_c) min_q[idx_q] <= SAMPLE_BITS'(raw_c);
      if (raw_c > max_c) max_q[idx_q] <= SAMPLE_BITS'(raw_c);
    end
  end

  // Scan accumulators and remembered position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      ws_q       <= '0;
      act_q      <= '0;
      last_pos_q <= '0;
    end else if (cmd_i.do_clr) begin
      sum_q      <= '0;
      ws_q       <= '0;
      act_q      <= '0;
      last_pos_q <= '0;
    end else begin
      // A scan starts at sensor zero
      if (cmd_i.do_mul && idx_q == '0) begin
        sum_q <= '0;
        ws_q  <= '0;
        act_q <= '0;
      end
      if (cmd_i.do_acc && in_cnt) begin
        sum_q <= sum_q + SumW'(norm_q);
        ws_q  <= ws_q + WsW'(prod_q);
        if (norm_q >= alev_q && act_q < 5'd31) act_q <= act_q + 5'd1;
      end
      if (cmd_i.cdiv_take) last_pos_q <= cent_d;
    end
  end

  // Staged result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_mul) begin
      res_done_q  <= 1'b0;
      res_pos_q   <= '0;
      res_lost_q  <= 1'b0;
      res_cross_q <= 1'b0;
    end
    if (cmd_i.fin_lost) begin
      res_done_q <= 1'b1;
      res_lost_q <= 1'b1;
      res_pos_q  <= last_pos_q;
    end
    if (cmd_i.cdiv_take) begin
      res_done_q  <= 1'b1;
      res_pos_q   <= cent_d;
      res_cross_q <= act_q >= mina_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_item_q.normalized <= norm_q;
      out_item_q.scan_done  <= res_done_q;
      out_item_q.position   <= res_pos_q;
      out_item_q.line_lost  <= res_lost_q;
      out_item_q.crossing   <= res_cross_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign status_o.op       = op_q;
  assign status_o.div_done = div_done;
  assign status_o.last     = in_cnt && (CntW'(idx_q) == cnt_eff - CntW'(1));
  assign status_o.lost     = lost;
  assign status_o.out_full = out_valid_q & ~out_ready_i;

  // A waiting result is never dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("result dropped while stalled");

  // The centroid division never sees a zero divisor
  a_cdiv_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cdiv_start |-> sum_q != '0)
    else $error("centroid division by zero sum");

  // Quotients are taken only when the divider has finished
  a_take_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.norm_take || cmd_i.cdiv_take) |-> div_done)
    else $error("quotient taken before division done");

  // Normalized value stays within full scale
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.norm_take |=> norm_q <= nmax_q)
    else $error("normalized value above full scale");

endmodule

// ----- rtl/core/lscc_ctrl.sv -----
// Controller: sequences one item at a time through the datapath.
module lscc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lscc_pkg::status_t status_i,
  output lscc_pkg::cmd_t    cmd_o
);
  import lscc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_PREP = 4'd2;
  localparam logic [3:0] S_NDIV = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_CDIV = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state_q;
  logic [3:0] state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        unique case (status_i.op)
          OP_CALIBRATE: begin
            cmd_o.do_cal = 1'b1;
            state_d      = S_IDLE;
          end
          OP_MEASURE: begin
            cmd_o.prep_num = 1'b1;
            state_d        = S_PREP;
          end
          OP_CLEAR: begin
            cmd_o.do_clr = 1'b1;
            state_d      = S_IDLE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_PREP: begin
        cmd_o.norm_start = 1'b1;
        state_d          = S_NDIV;
      end
      S_NDIV: begin
        if (status_i.div_done) begin
          cmd_o.norm_take = 1'b1;
          state_d         = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.do_mul = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.do_acc = 1'b1;
        state_d      = status_i.last ? S_FIN : S_OUT;
      end
      S_FIN: begin
        if (status_i.lost) begin
          cmd_o.fin_lost = 1'b1;
          state_d        = S_OUT;
        end else begin
          cmd_o.cdiv_start = 1'b1;
          state_d          = S_CDIV;
        end
      end
      S_CDIV: begin
        if (status_i.div_done) begin
          cmd_o.cdiv_take = 1'b1;
          state_d         = S_OUT;
        end
      end
      S_OUT: begin
        if (!status_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/line_sensor_calibrate_and_centroid_top.sv -----
// Top level of the line sensor calibrate-and-centroid block.
// Each input item carries one sensor sample and an operation. A calibrate item widens
// that sensor's min/max window and a clear item resets all windows, the scan sums and the
// remembered position; both give no result. A measure item returns one result: the
// sample normalized against its window, plus on the last sensor of a scan the centroid
// in sensor pitch units with line-lost and crossing flags. Items are handled one at a
// time; a measure item's sample is normalized in the 24-step short mode of the radix-2
// divider, and the last sensor of a scan adds a W-bit centroid division on the same
// divider (W = weighted-sum width, 35 at the default parameters) unless the line is lost.
// A finished result waits in an output register, so the next item is taken while it is
// still unread. Configuration writes are taken in any cycle but are meant to be issued
// only while the block is idle.
module line_sensor_calibrate_and_centroid_top #(
  parameter int unsigned MAX_SENSOR_COUNT = 16,
  parameter int unsigned SAMPLE_BITS      = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lscc_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lscc_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lscc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lscc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lscc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Configuration writes complete at once
  assign cfg_ready_o = 1'b1;

  lscc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lscc_datapath #(
    .MAX_SENSOR_COUNT (MAX_SENSOR_COUNT),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
